// ===== rtl/core/sfc_pkg.sv =====
// Shared types and constants for the sphere frustum cull test.
// No dependencies; used by sfc_mul and sphere_frustum_cull_test.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  // request kinds carried in the input tuser
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TEST = 1'b1
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_VIEW_RANGE = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Z   = 2'd3;

  localparam int MATRIX_FRAC_BITS_DEF = 24;
  localparam int COORD_FRAC_BITS      = 16;

  // multiplier operand and product widths
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 40;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // plane accumulation width
  localparam int PLANE_W = 96;

endpackage

`default_nettype wire

// ===== rtl/core/sfc_mul.sv =====
// Two-stage signed 48x40 multiplier built from four narrow partial products.
// Depends on sfc_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module sfc_mul
  import sfc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [MUL_A_W-1:0]   a,
  input  wire logic signed [MUL_B_W-1:0]   b,
  output logic signed [MUL_P_W-1:0]        prod
);

  localparam int AL = MUL_A_W / 2;
  localparam int BL = MUL_B_W / 2;

  logic signed [AL:0]          a_lo;
  logic signed [MUL_A_W-AL-1:0] a_hi;
  logic signed [BL:0]          b_lo;
  logic signed [MUL_B_W-BL-1:0] b_hi;

  logic signed [MUL_P_W-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;

  // low halves are unsigned, so they get a zero sign bit
  assign a_lo = {1'b0, a[AL-1:0]};
  assign a_hi = a[MUL_A_W-1:AL];
  assign b_lo = {1'b0, b[BL-1:0]};
  assign b_hi = b[MUL_B_W-1:BL];

  // first stage: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= MUL_P_W'(a_lo * b_lo);
      pp_lh_r <= MUL_P_W'(a_lo * b_hi);
      pp_hl_r <= MUL_P_W'(a_hi * b_lo);
      pp_hh_r <= MUL_P_W'(a_hi * b_hi);
    end
  end

  // second stage: weighted sum
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= pp_ll_r + (pp_lh_r <<< BL) + (pp_hl_r <<< AL) + (pp_hh_r <<< (AL + BL));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sphere_frustum_cull_test.sv =====
// Top level of the sphere frustum cull test: matrix store, pipeline, result register.
// Depends on sfc_pkg and sfc_mul.
//
// Usage: the input stream carries two kinds of transfer, selected by in_tuser.
// A load transfer writes one of the 16 view-projection matrix entries; it yields
// no result. A test transfer carries a sphere center and radius and yields one
// output transfer with the visible and out_of_range flags.
// Items pass through five register stages (entry, partial products, products,
// plane sums, output).
// One item is taken every cycle unless the output stalls; the rate is set by the
// fully pipelined multiplier array, twelve matrix products and three squares per item.
// Loads are applied to the store in pipeline order, so a test sees exactly the
// loads that came before it.
// Reset clears the matrix store, the configuration registers and all valid bits.
// When the receiver holds out_tready low with a result pending, the whole
// pipeline holds and in_tready drops; nothing is lost or repeated.
// Configuration writes on the cfg_ port must be made only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sphere_frustum_cull_test
  import sfc_pkg::*;
#(
  parameter int MATRIX_FRAC_BITS = MATRIX_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // fields from bit 0: entry_index[3:0], entry_value[47:0], center_x[31:0],
  // center_y[31:0], center_z[31:0], sphere_radius[30:0], zero fill
  input  wire logic [183:0] in_tdata,
  // fields from bit 0: req_type
  input  wire logic [0:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // fields from bit 0: visible, out_of_range, zero fill
  output logic [7:0]        out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_wen,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int P_W   = 39;  // scaled center
  localparam int RAD_W = 39;  // scaled radius
  localparam int D2_W  = 82;

  localparam logic [1:0] PLANE_COL [6] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [5:0] PLANE_NEG = 6'b100110;  // bit k set: base minus side

  // configuration
  logic [30:0]        view_range_r;
  logic signed [31:0] origin_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_range_r <= '0;
      origin_r[0]  <= '0;
      origin_r[1]  <= '0;
      origin_r[2]  <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_VIEW_RANGE: view_range_r <= cfg_wdata[30:0];
        CFG_ORIGIN_X:   origin_r[0]  <= cfg_wdata;
        CFG_ORIGIN_Y:   origin_r[1]  <= cfg_wdata;
        CFG_ORIGIN_Z:   origin_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: output register empty or being taken
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // input field unpack
  logic                     in_xfer;
  req_t                     in_type;
  logic signed [31:0]       in_c [3];
  logic [30:0]              in_rad;
  logic signed [P_W-1:0]    in_p [3];
  logic signed [P_W:0]      in_d [3];

  assign in_xfer = in_tvalid && adv;
  assign in_type = req_t'(in_tuser[0]);
  assign in_c[0] = $signed(in_tdata[83:52]);
  assign in_c[1] = $signed(in_tdata[115:84]);
  assign in_c[2] = $signed(in_tdata[147:116]);
  assign in_rad  = in_tdata[178:148];

  // scaled center (X mirrored) and offset from the view origin
  always_comb begin
    in_p[0] = -(P_W'(in_c[0]) * P_W'(100));
    in_p[1] = P_W'(in_c[1]) * P_W'(100);
    in_p[2] = P_W'(in_c[2]) * P_W'(100);
    for (int i = 0; i < 3; i++) begin
      in_d[i] = (P_W + 1)'(in_p[i]) - (P_W + 1)'(origin_r[i]);
    end
  end

  // stage 1 registers
  logic                  s1_valid_r;
  req_t                  s1_type_r;
  logic [3:0]            s1_idx_r;
  logic signed [47:0]    s1_val_r;
  logic signed [P_W-1:0] s1_p_r [3];
  logic signed [P_W:0]   s1_d_r [3];
  logic [RAD_W-1:0]      s1_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_type_r <= in_type;
      s1_idx_r  <= in_tdata[3:0];
      s1_val_r  <= $signed(in_tdata[51:4]);
      s1_p_r    <= in_p;
      s1_d_r    <= in_d;
      s1_rad_r  <= RAD_W'(in_rad) * RAD_W'(200);
    end
  end

  // matrix store, written as a load leaves stage 1
  logic signed [47:0] mat_r [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < 16; e++) begin
        mat_r[e] <= '0;
      end
    end else if (adv && s1_valid_r && s1_type_r == REQ_LOAD) begin
      mat_r[s1_idx_r] <= s1_val_r;
    end
  end

  // product array: entry (i,j) times center component i, plus three squares
  logic signed [MUL_P_W-1:0] prod [3][4];
  logic signed [MUL_P_W-1:0] sq [3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 4; gj++) begin : g_col
      sfc_mul u_mul (
        .clk  (clk),
        .en   (adv),
        .a    (mat_r[gi*4+gj]),
        .b    (MUL_B_W'(s1_p_r[gi])),
        .prod (prod[gi][gj])
      );
    end
    sfc_mul u_sq (
      .clk  (clk),
      .en   (adv),
      .a    (MUL_A_W'(s1_d_r[gi])),
      .b    (MUL_B_W'(s1_d_r[gi])),
      .prod (sq[gi])
    );
  end

  // constant terms per plane, from the bottom matrix row and the radius
  logic signed [PLANE_W-1:0] cterm [6];
  logic signed [PLANE_W-1:0] rad_w;

  always_comb begin
    rad_w = $signed(PLANE_W'(s1_rad_r) << MATRIX_FRAC_BITS);
    for (int k = 0; k < 6; k++) begin
      if (PLANE_NEG[k]) begin
        cterm[k] = ((PLANE_W'(mat_r[15]) - PLANE_W'(mat_r[{2'd3, PLANE_COL[k]}]))
                    <<< COORD_FRAC_BITS) + rad_w;
      end else begin
        cterm[k] = ((PLANE_W'(mat_r[15]) + PLANE_W'(mat_r[{2'd3, PLANE_COL[k]}]))
                    <<< COORD_FRAC_BITS) + rad_w;
      end
    end
  end

  // stages 2 and 3: carry the constant terms along with the products
  logic                      s2_valid_r, s3_valid_r;
  req_t                      s2_type_r, s3_type_r;
  logic signed [PLANE_W-1:0] s2_cterm_r [6];
  logic signed [PLANE_W-1:0] s3_cterm_r [6];
  logic [61:0]               lim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_type_r  <= s1_type_r;
      s3_type_r  <= s2_type_r;
      s2_cterm_r <= cterm;
      s3_cterm_r <= s2_cterm_r;
    end
    lim2_r <= 62'(view_range_r) * 62'(view_range_r);
  end

  // plane totals and squared distance
  logic signed [PLANE_W-1:0] plane [6];
  logic [D2_W-1:0]           dist2;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      plane[k] = s3_cterm_r[k];
      for (int i = 0; i < 3; i++) begin
        if (PLANE_NEG[k]) begin
          plane[k] = plane[k] + PLANE_W'(prod[i][3]) - PLANE_W'(prod[i][PLANE_COL[k]]);
        end else begin
          plane[k] = plane[k] + PLANE_W'(prod[i][3]) + PLANE_W'(prod[i][PLANE_COL[k]]);
        end
      end
    end
    dist2 = D2_W'(sq[0][79:0]) + D2_W'(sq[1][79:0]) + D2_W'(sq[2][79:0]);
  end

  // stage 4 registers
  logic                      s4_valid_r;
  req_t                      s4_type_r;
  logic [5:0]                s4_pos_r;
  logic [D2_W-1:0]           s4_dist2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_type_r  <= s3_type_r;
      s4_dist2_r <= dist2;
      for (int k = 0; k < 6; k++) begin
        s4_pos_r[k] <= plane[k] > 0;
      end
    end
  end

  // output register
  logic far_away;
  logic vis_r, far_r;

  assign far_away = (view_range_r != '0) && (s4_dist2_r > D2_W'(lim2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_valid_r && s4_type_r == REQ_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      far_r <= far_away;
      vis_r <= !far_away && (&s4_pos_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, far_r, vis_r};

endmodule

`default_nettype wire
